FILE: src/mac_table_with_aging_assert.svh
// Assertion macros for the MAC table with aging.
`ifndef MAC_TABLE_WITH_AGING_ASSERT_SVH
`define MAC_TABLE_WITH_AGING_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define MTWA_ASSERT_NOW(label, clk, rstn, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
    else $error(msg);

// Condition implies consequence in the next cycle.
`define MTWA_ASSERT_NEXT(label, clk, rstn, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/mtwa_pkg.sv
// ----------------------------------------------------------------------------
// mtwa_pkg
// Types and codes shared by the MAC table cells and the controller.
// ----------------------------------------------------------------------------
`default_nettype none
package mtwa_pkg;

  localparam int unsigned NUM_W = 11;
  localparam int unsigned MAC_W = 48;

  localparam logic [1:0] CMD_TOUCH  = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_SWEEP  = 2'd2;

  localparam logic [2:0] ST_FOUND    = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_MISS     = 3'd3;
  localparam logic [2:0] ST_SWEPT    = 3'd4;

  typedef struct packed {
    logic             vld;
    logic [1:0]       cmd;
    logic [MAC_W-1:0] mac;
    logic             hit;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] free;
    logic [NUM_W-1:0] removed;
  } tok_t;

  typedef struct packed {
    logic             we;
    logic [NUM_W-1:0] num;
    logic [MAC_W-1:0] mac;
  } wr_t;

endpackage
`default_nettype wire

FILE: src/mtwa_if.sv
// ----------------------------------------------------------------------------
// mtwa_in_if / mtwa_out_if
// Valid/ready channels for commands and results of the MAC table.
// ----------------------------------------------------------------------------
`default_nettype none
interface mtwa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [47:0] mac_address;
  modport source (output valid, command, mac_address, input ready);
  modport sink (input valid, command, mac_address, output ready);
endinterface

interface mtwa_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [6:0] entry_number;
  logic [6:0] removed_count;
  modport source (output valid, status, entry_number, removed_count, input ready);
  modport sink (input valid, status, entry_number, removed_count, output ready);
endinterface
`default_nettype wire

FILE: src/mtwa_cell.sv
// ----------------------------------------------------------------------------
// mtwa_cell
// One table entry; updates itself as the command token passes and hands the
// token on to the next entry through its token register.
// ----------------------------------------------------------------------------
`default_nettype none
module mtwa_cell #(
  parameter int unsigned SLOT = 0
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [1:0]     limit_i,
  input  wire mtwa_pkg::wr_t  wr_i,
  input  wire mtwa_pkg::tok_t tok_i,
  output mtwa_pkg::tok_t      tok_o
);
  localparam int unsigned W = mtwa_pkg::NUM_W;
  localparam logic [W-1:0] SLOT_NUM = W'(SLOT + 1);

  logic                      valid_q, valid_d;
  logic [1:0]                age_q, age_d;
  logic [mtwa_pkg::MAC_W-1:0] mac_q, mac_d;
  mtwa_pkg::tok_t            tok_q, tok_d;

  always_comb begin
    valid_d = valid_q;
    age_d   = age_q;
    mac_d   = mac_q;
    tok_d   = tok_i;
    if (tok_i.vld) begin
      if (tok_i.cmd == mtwa_pkg::CMD_SWEEP) begin
        if (valid_q) begin
          if (age_q >= limit_i) begin
            valid_d = 1'b0;
            age_d = 2'd0;
            tok_d.removed = tok_i.removed + W'(1);
          end else begin
            age_d = age_q + 2'd1;
          end
        end
      end else if (tok_i.cmd == mtwa_pkg::CMD_TOUCH || tok_i.cmd == mtwa_pkg::CMD_LOOKUP) begin
        if (valid_q && mac_q == tok_i.mac && !tok_i.hit) begin
          tok_d.hit = 1'b1;
          tok_d.num = SLOT_NUM;
          if (tok_i.cmd == mtwa_pkg::CMD_TOUCH) age_d = 2'd0;
        end
        if (!valid_q && tok_i.free == '0) tok_d.free = SLOT_NUM;
      end
    end
    if (wr_i.we && wr_i.num == SLOT_NUM) begin
      valid_d = 1'b1;
      age_d = 2'd0;
      mac_d = wr_i.mac;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      age_q   <= 2'd0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      age_q   <= age_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mac_q <= mac_d;
  end

  assign tok_o = tok_q;
endmodule
`default_nettype wire

FILE: src/mac_table_with_aging.sv
// ----------------------------------------------------------------------------
// mac_table_with_aging
// MAC address table with touch, lookup and age sweep over a row of entries.
// ----------------------------------------------------------------------------
// Each command travels as a token through a row of ENTRY_COUNT entry cells,
// one cell per cycle. The accepted command is registered before the first
// cell, and its result is registered at the output, or held as pending, as
// the token leaves the last cell. One command is in the row at a time. A
// finished result may wait at the output while the next command runs. A
// second finished result held behind it stalls the input until the output
// drains. An insert is written into the lowest free entry as the token
// leaves the row. All entries are free after reset.
`default_nettype none
`include "mac_table_with_aging_assert.svh"
module mac_table_with_aging #(
  parameter int unsigned ENTRY_COUNT = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_data_i,
  mtwa_in_if.sink         in_i,
  mtwa_out_if.source      out_o
);
  localparam int unsigned W = mtwa_pkg::NUM_W;

  mtwa_pkg::tok_t tok [ENTRY_COUNT+1];
  mtwa_pkg::tok_t inj_q, inj_d, end_tok;
  mtwa_pkg::wr_t  wr;

  logic [1:0] limit_q;
  logic       busy_q, busy_d;
  logic       pend_q, pend_d, ovld_q, ovld_d;
  logic [2:0] res_st, pst_q, pst_d, ost_q, ost_d;
  logic [6:0] res_en, pen_q, pen_d, oen_q, oen_d;
  logic [6:0] res_rm, prm_q, prm_d, orm_q, orm_d;
  logic       in_acc, res_fire, out_free;

  assign tok[0] = inj_q;
  assign end_tok = tok[ENTRY_COUNT];

  for (genvar g = 0; g < ENTRY_COUNT; g++) begin : g_cell
    mtwa_cell #(.SLOT(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .limit_i(limit_q),
      .wr_i   (wr),
      .tok_i  (tok[g]),
      .tok_o  (tok[g+1])
    );
  end

  assign in_i.ready = !busy_q && !pend_q;
  assign in_acc = in_i.valid && in_i.ready;
  assign res_fire = end_tok.vld;
  assign out_free = !ovld_q || out_o.ready;

  always_comb begin
    res_st = mtwa_pkg::ST_MISS;
    res_en = 7'd0;
    res_rm = 7'd0;
    wr.we = 1'b0;
    wr.num = end_tok.free;
    wr.mac = end_tok.mac;
    if (end_tok.cmd == mtwa_pkg::CMD_SWEEP) begin
      res_st = mtwa_pkg::ST_SWEPT;
      res_rm = end_tok.removed[6:0];
    end else if (end_tok.hit &&
                 (end_tok.cmd == mtwa_pkg::CMD_TOUCH || end_tok.cmd == mtwa_pkg::CMD_LOOKUP)) begin
      res_st = mtwa_pkg::ST_FOUND;
      res_en = end_tok.num[6:0];
    end else if (end_tok.cmd == mtwa_pkg::CMD_TOUCH) begin
      if (end_tok.free != '0) begin
        res_st = mtwa_pkg::ST_INSERTED;
        res_en = end_tok.free[6:0];
        wr.we = res_fire;
      end else begin
        res_st = mtwa_pkg::ST_FULL;
      end
    end
  end

  always_comb begin
    inj_d = '0;
    if (in_acc) begin
      inj_d.vld = 1'b1;
      inj_d.cmd = in_i.command;
      inj_d.mac = in_i.mac_address;
    end
    busy_d = busy_q;
    if (in_acc) busy_d = 1'b1;
    if (res_fire) busy_d = 1'b0;
    ovld_d = ovld_q && !out_o.ready;
    ost_d = ost_q;
    oen_d = oen_q;
    orm_d = orm_q;
    pend_d = pend_q;
    pst_d = pst_q;
    pen_d = pen_q;
    prm_d = prm_q;
    if (out_free) begin
      if (pend_q) begin
        ovld_d = 1'b1;
        ost_d = pst_q;
        oen_d = pen_q;
        orm_d = prm_q;
        pend_d = 1'b0;
      end else if (res_fire) begin
        ovld_d = 1'b1;
        ost_d = res_st;
        oen_d = res_en;
        orm_d = res_rm;
      end
    end else if (res_fire) begin
      pend_d = 1'b1;
      pst_d = res_st;
      pen_d = res_en;
      prm_d = res_rm;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 2'd2;
      busy_q  <= 1'b0;
      pend_q  <= 1'b0;
      ovld_q  <= 1'b0;
      inj_q   <= '0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_data_i;
      busy_q <= busy_d;
      pend_q <= pend_d;
      ovld_q <= ovld_d;
      inj_q  <= inj_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ost_q <= ost_d;
    oen_q <= oen_d;
    orm_q <= orm_d;
    pst_q <= pst_d;
    pen_q <= pen_d;
    prm_q <= prm_d;
  end

  assign out_o.valid = ovld_q;
  assign out_o.status = ost_q;
  assign out_o.entry_number = oen_q;
  assign out_o.removed_count = orm_q;

  `MTWA_ASSERT_NEXT(a_acc_busy, clk_i, rst_ni, in_acc, busy_q, "accepted command not busy")
  `MTWA_ASSERT_NOW(a_end_busy, clk_i, rst_ni, res_fire, busy_q, "result without command")
  `MTWA_ASSERT_NOW(a_pend_out, clk_i, rst_ni, pend_q, ovld_q, "pending result with empty output")
  `MTWA_ASSERT_NOW(a_wr_free, clk_i, rst_ni, wr.we, wr.num != '0 && res_fire, "bad insert write")
endmodule
`default_nettype wire
